### rtl/core/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg: shared constants for the POV column scanner
// Default geometry, timer shift and reset value of the period threshold.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int COLUMNS_DEF         = 128;
  localparam int PERIOD_SHIFT_DEF    = 7;
  localparam int FRAMES_PER_TURN_DEF = 1;

  localparam int PERIOD_W = 16;
  localparam int WIDX_W   = 7;
  localparam int BYTE_W   = 8;
  localparam int FRAMES_W = 2;
  localparam int PIXEL_W  = 3 * BYTE_W;

  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET = 16'd12000;

endpackage

### rtl/core/pcs_ram.sv
// ----------------------------------------------------------------------------
// pcs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/pov_column_scanner.sv
// ----------------------------------------------------------------------------
// pov_column_scanner: persistence-of-vision column scanner
// Frame store, scroll offset and scan counters driving an RGB LED column.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle, sustained while the output
// side is ready, and returns one result word for each, in order. A word
// passes stage 1 and the output register: a column tick issues its frame
// store read at the acceptance edge and the registered read data joins the
// decision held in stage 1. Scan state (column, columns left, frames
// shown, scroll offset) lives in flip-flops and is updated at acceptance, so
// back-to-back ticks need no forwarding. A write lands in the RAM at its own
// acceptance edge, so a tick right behind it already reads the new bytes. One
// valid bit per column, cleared by reset, makes a column that was never
// written read as zero; there is no clearing pass. A pipeline stage plus an
// output register part the two sides, so one more word is taken while a
// finished result waits on out_tready.
// ----------------------------------------------------------------------------
module pov_column_scanner #(
  parameter int COLUMNS         = pcs_pkg::COLUMNS_DEF,
  parameter int PERIOD_SHIFT    = pcs_pkg::PERIOD_SHIFT_DEF,
  parameter int FRAMES_PER_TURN = pcs_pkg::FRAMES_PER_TURN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, from bit 0: period_ticks[15:0], write_index[22:16],
  // red_in[30:23], green_in[38:31], blue_in[46:39], forward[47]
  input  logic [47:0] in_tdata,
  // in_tuser: mode[1:0]
  input  logic [1:0]  in_tuser,

  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, from bit 0: red_out[7:0], green_out[15:8], blue_out[23:16],
  // reload_value[31:24]
  output logic [31:0] out_tdata,
  // out_tuser, from bit 0: light_action[1:0], reload_valid[2]
  output logic [2:0]  out_tuser,

  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = $clog2(COLUMNS);
  localparam int LW = $clog2(COLUMNS + 1);
  localparam int BW = pcs_pkg::BYTE_W;
  localparam int PW = pcs_pkg::PIXEL_W;
  localparam int FW = pcs_pkg::FRAMES_W;

  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
  localparam logic [LW-1:0] FULL_COUNT = LW'(COLUMNS);
  localparam logic [FW-1:0] FRAMES_MAX = FW'(FRAMES_PER_TURN);

  typedef enum logic [1:0] {
    MODE_ROTATE = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_SCROLL = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SHOW  = 2'd1,
    ACT_SLEEP = 2'd2
  } action_t;

  typedef enum logic {
    REG_MIN_PERIOD = 1'b0,
    REG_UNUSED     = 1'b1
  } reg_idx_t;

  // --------------------------------------------------------------------------
  // unpack the input word
  // --------------------------------------------------------------------------
  mode_t                         in_mode;
  logic [pcs_pkg::PERIOD_W-1:0]  in_period;
  logic [pcs_pkg::WIDX_W-1:0]    in_widx;
  logic [BW-1:0]                 in_red;
  logic [BW-1:0]                 in_green;
  logic [BW-1:0]                 in_blue;
  logic                          in_fwd;

  assign in_mode   = mode_t'(in_tuser);
  assign in_period = in_tdata[15:0];
  assign in_widx   = in_tdata[22:16];
  assign in_red    = in_tdata[30:23];
  assign in_green  = in_tdata[38:31];
  assign in_blue   = in_tdata[46:39];
  assign in_fwd    = in_tdata[47];

  // --------------------------------------------------------------------------
  // configuration port: always ready, one register
  // --------------------------------------------------------------------------
  logic [pcs_pkg::PERIOD_W-1:0] min_period_r;
  reg_idx_t                     cfg_idx;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_PERIOD: cfg_prdata = 32'(min_period_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= pcs_pkg::MIN_PERIOD_RESET;
    end else if (cfg_wr && cfg_idx == REG_MIN_PERIOD) begin
      min_period_r <= cfg_pwdata[pcs_pkg::PERIOD_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // handshake: stage 1 waits on the output register, the output register on the sink
  // --------------------------------------------------------------------------
  logic s1_v_r;
  logic out_v_r;
  logic s1_move;
  logic acc;

  assign s1_move   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_move;
  assign acc       = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // scan state and per-item decisions, all settled at acceptance
  // --------------------------------------------------------------------------
  logic [CW-1:0]    scroll_r, scroll_nxt;
  logic [CW-1:0]    scan_col_r, scan_col_nxt;
  logic [LW-1:0]    cols_left_r, cols_left_nxt;
  logic [FW-1:0]    frames_r, frames_nxt;
  logic [COLUMNS-1:0] vld_r;

  action_t          act;
  logic             rv;
  logic [BW-1:0]    rval;
  logic             ram_we;
  logic             ram_re;
  logic [CW-1:0]    ram_waddr;
  logic [PW-1:0]    ram_wdata;
  logic [PW-1:0]    ram_rdata;
  logic             widx_ok;
  logic [LW-1:0]    cols_dec;

  assign widx_ok   = {1'b0, in_widx} < 8'(COLUMNS);
  assign ram_waddr = in_widx[CW-1:0];
  assign ram_wdata = {in_red, in_green, in_blue};
  assign cols_dec  = cols_left_r - LW'(1);

  always_comb begin
    scroll_nxt    = scroll_r;
    scan_col_nxt  = scan_col_r;
    cols_left_nxt = cols_left_r;
    frames_nxt    = frames_r;
    act           = ACT_NONE;
    rv            = 1'b0;
    rval          = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (in_mode)
      MODE_ROTATE: begin
        // restart the scan at the scroll offset
        scan_col_nxt  = scroll_r;
        cols_left_nxt = FULL_COUNT;
        frames_nxt    = '0;
        if (in_period > min_period_r) begin
          rv   = 1'b1;
          rval = ~BW'(in_period >> PERIOD_SHIFT);
        end
      end
      MODE_TICK: begin
        if (frames_r < FRAMES_MAX) begin
          act          = ACT_SHOW;
          ram_re       = acc;
          scan_col_nxt = (scan_col_r == LAST_COL) ? '0 : scan_col_r + CW'(1);
          if (cols_dec == '0) begin
            frames_nxt    = frames_r + FW'(1);
            cols_left_nxt = FULL_COUNT;
          end else begin
            cols_left_nxt = cols_dec;
          end
        end else begin
          act = ACT_SLEEP;
        end
      end
      MODE_WRITE: begin
        ram_we = acc && widx_ok;
      end
      MODE_SCROLL: begin
        if (in_fwd) begin
          scroll_nxt = (scroll_r == LAST_COL) ? '0 : scroll_r + CW'(1);
        end else begin
          scroll_nxt = (scroll_r == '0) ? LAST_COL : scroll_r - CW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_r    <= '0;
      scan_col_r  <= '0;
      cols_left_r <= FULL_COUNT;
      frames_r    <= '0;
      vld_r       <= '0;
    end else begin
      if (acc) begin
        scroll_r    <= scroll_nxt;
        scan_col_r  <= scan_col_nxt;
        cols_left_r <= cols_left_nxt;
        frames_r    <= frames_nxt;
      end
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  pcs_ram #(
    .WIDTH (PW),
    .DEPTH (COLUMNS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_col_r),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // stage 1: hold the decision until the read data arrives
  // --------------------------------------------------------------------------
  action_t       s1_act_r;
  logic          s1_rv_r;
  logic [BW-1:0] s1_rval_r;
  logic          s1_hit_r;
  logic [PW-1:0] s1_pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_act_r  <= act;
      s1_rv_r   <= rv;
      s1_rval_r <= rval;
      s1_hit_r  <= vld_r[scan_col_r];
    end
  end

  // drop the bytes unless this is a shown column that was ever written
  assign s1_pix = (s1_act_r == ACT_SHOW && s1_hit_r) ? ram_rdata : '0;

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  action_t       out_act_r;
  logic [PW-1:0] out_pix_r;
  logic          out_rv_r;
  logic [BW-1:0] out_rval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_act_r  <= s1_act_r;
      out_pix_r  <= s1_pix;
      out_rv_r   <= s1_rv_r;
      out_rval_r <= s1_rval_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_rval_r, out_pix_r[BW-1:0], out_pix_r[2*BW-1:BW],
                       out_pix_r[PW-1:2*BW]};
  assign out_tuser  = {out_rv_r, out_act_r};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_read_when_stalled : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_move) |-> !ram_re)
    else $error("frame store read issued while stage 1 is stalled");

  a_reload_only_on_rotate : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_rv_r) |-> (out_act_r == ACT_NONE))
    else $error("timer reload paired with a light action");

  a_scan_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (32'(scan_col_r) < COLUMNS) && (32'(scroll_r) < COLUMNS))
    else $error("scan column or scroll offset beyond the frame");

  a_count_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (cols_left_r != '0) && (cols_left_r <= FULL_COUNT) && (frames_r <= FRAMES_MAX))
    else $error("column or frame count out of range");

  a_sleep_no_bytes : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_act_r != ACT_SHOW) |-> (out_pix_r == '0))
    else $error("color bytes given without showing a column");

endmodule
